[hdl/assert_macros.svh]
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define ASSERT_AT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
// consequent holds at the next clock edge after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_AT(lbl, cond)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/mfrb_pkg.sv]
// shared types and constants of the median filter
package mfrb_pkg;

	localparam int FW_W       = 11;
	localparam int HEIGHT_W   = 13;
	localparam int ROW_W      = 12;
	localparam int RAD_W      = 2;
	localparam int MAX_HEIGHT = 4096;
	localparam int OUT_DEPTH  = 8;
	localparam int PTR_W      = 3;
	localparam int CNT_W      = 4;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_RADIUS = 2'd2
	} cfg_reg_t;

	// tag that travels with a window through the median pipeline
	typedef struct packed {
		logic valid;
		logic last;
	} med_meta_t;

endpackage

[hdl/median_filter_replicated_border_top.sv]
// top level of the streaming median filter with replicated border
// Streaming (2R+1)x(2R+1) median filter, R = 0..MAX_RADIUS, over raster pixels with
// edge replication. One beat is taken per clock unless the input stalls. The line
// store is a ring of 2*MAX_RADIUS+2 rows (one line ram of MAX_WIDTH pixels per row,
// one read port each); a result whose column is zero needs R extra column reads for
// its left border, so the input stalls for them once per output row. A result reaches
// the output fifo through the ram read, window and median registers, after the border
// reads at a row start; the fifo holds eight results and the input backs off when it
// would overflow. Flush beats (tuser high) drain results still pending after the last
// pixel. The line rams are neither cleared nor tracked after reset: the filter only
// reads pixels of the current frame. A width, height or radius write restarts it.
`include "assert_macros.svh"

module median_filter_replicated_border_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 2,
	parameter int PIXEL_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave side: tdata = pixel_in, tuser = kind
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]   s_tdata,
	input  logic [0:0]                        s_tuser,
	// master side: tdata = pixel_out, tlast = frame_last
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((PIXEL_BITS+7)/8)*8-1:0]   m_tdata,
	output logic                              m_tlast,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [mfrb_pkg::HEIGHT_W-1:0]     cfg_data
);

	localparam int DW   = ((PIXEL_BITS + 7) / 8) * 8;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WIN  = 2 * MAX_RADIUS + 1;
	localparam int RING = 2 * MAX_RADIUS + 2;
	localparam int SW   = $clog2(RING);
	localparam int PW   = $clog2(WIN);
	localparam int HW   = mfrb_pkg::HEIGHT_W;
	localparam int RW   = mfrb_pkg::ROW_W;
	localparam int AW   = mfrb_pkg::RAD_W;

	// read beat travelling to the cycle where ram data returns
	typedef struct packed {
		logic                   valid;
		logic                   shift;
		logic [PW-1:0]          pos;
		logic                   fill_left;
		logic                   last;
		logic                   flast;
		logic [WIN-1:0][SW-1:0] map;
		logic                   fwd;
		logic [SW-1:0]          fwd_slot;
		logic [PIXEL_BITS-1:0]  fwd_data;
	} rd_meta_t;

	// configuration registers
	logic [mfrb_pkg::FW_W-1:0] fw_q;
	logic [HW-1:0]             fh_q;
	logic [AW-1:0]             rad_q;
	logic [CW:0]               w_eff;
	logic [HW-1:0]             h_eff;
	logic [AW-1:0]             r_eff;
	logic                      cfg_wr;
	logic                      restart;

	// stream positions
	logic [CW-1:0] ic_q, oc_q, ic_n, oc_a, oc_n;
	logic [RW-1:0] ir_q, or_q, ir_n, or_a, or_n;
	logic [SW-1:0] islot_q, oslot_q, is_n, os_a, os_n;
	logic          fd_q, fd_a, fd_b, fd_n;

	logic                  acc, pix, emit, ready, flast;
	logic [PIXEL_BITS-1:0] pixel;
	logic [HW-1:0]         rsum, fr;
	logic [CW:0]           csum, fc, pcol;
	logic [SW-1:0]         map_a [WIN];

	// left border preload
	logic [AW-1:0]          pre_cnt_q, pre_j_q;
	logic [WIN-1:0][SW-1:0] pre_map_q;
	logic                   pre_fl_q, pre_act, pre_start;

	// line store
	logic [RING-1:0]       wr_en;
	logic [CW-1:0]         rd_addr;
	logic [PIXEL_BITS-1:0] ram_q [RING];
	rd_meta_t              rd_n, rd_s1;
	logic [PIXEL_BITS-1:0] colv [WIN];
	logic [PIXEL_BITS-1:0] win_q [WIN][WIN];

	// median and output
	mfrb_pkg::med_meta_t   med_in_s2, med_out;
	logic [PIXEL_BITS-1:0] med_pix;
	logic [PIXEL_BITS-1:0] fifo_pix_q [mfrb_pkg::OUT_DEPTH];
	logic                  fifo_last_q [mfrb_pkg::OUT_DEPTH];
	logic [mfrb_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [mfrb_pkg::CNT_W-1:0] fifo_cnt_q, pend_q;
	logic                  push, pop;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign pixel     = s_tdata[PIXEL_BITS-1:0];

	// zero acts as one, oversize saturates
	always_comb begin
		if (fw_q == '0) begin
			w_eff = (CW+1)'(1);
		end else if (HW'(fw_q) > HW'(MAX_WIDTH)) begin
			w_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW+1)'(fw_q);
		end
		if (fh_q == '0) begin
			h_eff = HW'(1);
		end else if (fh_q > HW'(mfrb_pkg::MAX_HEIGHT)) begin
			h_eff = HW'(mfrb_pkg::MAX_HEIGHT);
		end else begin
			h_eff = fh_q;
		end
		r_eff = (rad_q > AW'(MAX_RADIUS)) ? AW'(MAX_RADIUS) : rad_q;
	end

	always_comb begin
		restart = 1'b0;
		if (cfg_wr) begin
			unique case (cfg_index)
				mfrb_pkg::CFG_WIDTH,
				mfrb_pkg::CFG_HEIGHT,
				mfrb_pkg::CFG_RADIUS: restart = 1'b1;
				default:              restart = 1'b0;
			endcase
		end
	end

	assign pre_act  = (pre_cnt_q != '0);
	assign s_tready = !pre_act && (pend_q < mfrb_pkg::CNT_W'(mfrb_pkg::OUT_DEPTH));
	assign acc      = s_tvalid && s_tready;
	assign pix      = acc && !s_tuser[0];

	// input advance, readiness and output advance in item order
	always_comb begin
		fd_a = fd_q;
		oc_a = oc_q;
		or_a = or_q;
		os_a = oslot_q;
		// pixel after a finished frame abandons what is left of it
		if (pix && fd_q) begin
			fd_a = 1'b0;
			oc_a = '0;
			or_a = '0;
			os_a = '0;
		end
		ic_n = ic_q;
		ir_n = ir_q;
		is_n = islot_q;
		fd_b = fd_a;
		if (pix) begin
			if ({1'b0, ic_q} + (CW+1)'(1) >= w_eff) begin
				ic_n = '0;
				if ({1'b0, ir_q} + HW'(1) >= h_eff) begin
					ir_n = '0;
					is_n = '0;
					fd_b = 1'b1;
				end else begin
					ir_n = ir_q + RW'(1);
					is_n = (islot_q == SW'(RING - 1)) ? '0 : islot_q + SW'(1);
				end
			end else begin
				ic_n = ic_q + CW'(1);
			end
		end
		// last pixel the window needs, compared in raster order
		rsum = {1'b0, or_a} + HW'(r_eff);
		fr   = (rsum > h_eff - HW'(1)) ? h_eff - HW'(1) : rsum;
		csum = {1'b0, oc_a} + (CW+1)'(r_eff);
		fc   = (csum > w_eff - (CW+1)'(1)) ? w_eff - (CW+1)'(1) : csum;
		ready = fd_b || ({1'b0, ir_n} > fr) ||
			(({1'b0, ir_n} == fr) && ({1'b0, ic_n} > fc));
		emit  = acc && ready;
		oc_n  = oc_a;
		or_n  = or_a;
		os_n  = os_a;
		fd_n  = fd_b;
		flast = 1'b0;
		if (emit) begin
			if ({1'b0, oc_a} + (CW+1)'(1) >= w_eff) begin
				oc_n = '0;
				if ({1'b0, or_a} + HW'(1) >= h_eff) begin
					or_n  = '0;
					os_n  = '0;
					flast = 1'b1;
					fd_n  = 1'b0;
				end else begin
					or_n = or_a + RW'(1);
					os_n = (os_a == SW'(RING - 1)) ? '0 : os_a + SW'(1);
				end
			end else begin
				oc_n = oc_a + CW'(1);
			end
		end
	end

	// ring slot of each clamped window row
	always_comb begin
		logic signed [14:0] rowv, offv, yv, hm1, sv;
		for (int k = 0; k < WIN; k++) begin
			rowv = $signed({3'b0, or_a});
			offv = $signed(15'(k)) - $signed({13'b0, r_eff});
			yv   = rowv + offv;
			hm1  = $signed({2'b0, h_eff}) - 15'sd1;
			if (yv < 15'sd0) begin
				offv = -rowv;
			end else if (yv > hm1) begin
				offv = hm1 - rowv;
			end
			sv = $signed({{(15-SW){1'b0}}, os_a}) + offv;
			if (sv < 15'sd0) begin
				sv = sv + $signed(15'(RING));
			end else if (sv >= $signed(15'(RING))) begin
				sv = sv - $signed(15'(RING));
			end
			map_a[k] = sv[SW-1:0];
		end
	end

	// read beat: the new right column, or one left border column
	assign pre_start = emit && (oc_a == '0) && (r_eff != '0);
	assign pcol = ({{(CW+1-AW){1'b0}}, pre_j_q} > w_eff - (CW+1)'(1)) ?
		w_eff - (CW+1)'(1) : {{(CW+1-AW){1'b0}}, pre_j_q};

	always_comb begin
		rd_addr        = pre_act ? pcol[CW-1:0] : fc[CW-1:0];
		rd_n.valid     = pre_act || emit;
		rd_n.shift     = !pre_act && (oc_a != '0);
		rd_n.pos       = pre_act ? PW'({1'b0, r_eff} + {1'b0, pre_j_q}) : PW'({r_eff, 1'b0});
		rd_n.fill_left = pre_act && (pre_j_q == '0);
		rd_n.last      = pre_act ? (pre_cnt_q == AW'(1)) : !pre_start;
		rd_n.flast     = pre_act ? pre_fl_q : flast;
		for (int k = 0; k < WIN; k++) begin
			rd_n.map[k] = pre_act ? pre_map_q[k] : map_a[k];
		end
		// the pixel written this edge is not yet in the ram output
		rd_n.fwd      = pix && emit && (rd_addr == ic_q);
		rd_n.fwd_slot = islot_q;
		rd_n.fwd_data = pixel;
		for (int g = 0; g < RING; g++) begin
			wr_en[g] = pix && (islot_q == SW'(g));
		end
	end

	for (genvar g = 0; g < RING; g++) begin : g_line
		mfrb_ram #(
			.WIDTH(PIXEL_BITS),
			.DEPTH(MAX_WIDTH)
		) u_ram (
			.clk  (clk),
			.we   (wr_en[g]),
			.waddr(ic_q),
			.wdata(pixel),
			.raddr(rd_addr),
			.rdata(ram_q[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q      <= mfrb_pkg::FW_W'(640);
			fh_q      <= HW'(480);
			rad_q     <= AW'(1);
			ic_q      <= '0;
			ir_q      <= '0;
			islot_q   <= '0;
			oc_q      <= '0;
			or_q      <= '0;
			oslot_q   <= '0;
			fd_q      <= 1'b0;
			pre_cnt_q <= '0;
			pre_j_q   <= '0;
			rd_s1     <= '0;
			med_in_s2 <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					mfrb_pkg::CFG_WIDTH:  fw_q  <= cfg_data[mfrb_pkg::FW_W-1:0];
					mfrb_pkg::CFG_HEIGHT: fh_q  <= cfg_data;
					mfrb_pkg::CFG_RADIUS: rad_q <= cfg_data[AW-1:0];
					default:              ;
				endcase
			end
			if (restart) begin
				ic_q    <= '0;
				ir_q    <= '0;
				islot_q <= '0;
				oc_q    <= '0;
				or_q    <= '0;
				oslot_q <= '0;
				fd_q    <= 1'b0;
			end else begin
				ic_q    <= ic_n;
				ir_q    <= ir_n;
				islot_q <= is_n;
				oc_q    <= oc_n;
				or_q    <= or_n;
				oslot_q <= os_n;
				fd_q    <= fd_n;
			end
			if (pre_start) begin
				pre_cnt_q <= r_eff;
				pre_j_q   <= '0;
			end else if (pre_act) begin
				pre_cnt_q <= pre_cnt_q - AW'(1);
				pre_j_q   <= pre_j_q + AW'(1);
			end
			rd_s1           <= rd_n;
			med_in_s2.valid <= rd_s1.valid && rd_s1.last;
			med_in_s2.last  <= rd_s1.flast;
		end
	end

	always_ff @(posedge clk) begin
		if (pre_start) begin
			pre_map_q <= rd_n.map;
			pre_fl_q  <= flast;
		end
	end

	// column returned by the line rams, rows picked by slot
	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			colv[k] = (rd_s1.fwd && (rd_s1.map[k] == rd_s1.fwd_slot)) ?
				rd_s1.fwd_data : ram_q[rd_s1.map[k]];
		end
	end

	// window columns: shift for the next column, direct writes at a row start
	always_ff @(posedge clk) begin
		if (rd_s1.valid) begin
			for (int k = 0; k < WIN; k++) begin
				if (rd_s1.shift) begin
					for (int p = 0; p < WIN - 1; p++) begin
						win_q[k][p] <= (PW'(p) == PW'({r_eff, 1'b0})) ?
							colv[k] : win_q[k][p+1];
					end
					if (PW'({r_eff, 1'b0}) == PW'(WIN - 1)) begin
						win_q[k][WIN-1] <= colv[k];
					end
				end else begin
					if (rd_s1.fill_left) begin
						for (int p = 0; p < WIN; p++) begin
							if (PW'(p) < PW'(r_eff)) begin
								win_q[k][p] <= colv[k];
							end
						end
					end
					win_q[k][rd_s1.pos] <= colv[k];
				end
			end
		end
	end

	mfrb_median #(
		.PIXEL_BITS(PIXEL_BITS),
		.MAX_RADIUS(MAX_RADIUS)
	) u_median (
		.clk     (clk),
		.arst_n  (arst_n),
		.win     (win_q),
		.radius  (r_eff),
		.meta_in (med_in_s2),
		.meta_out(med_out),
		.pix_out (med_pix)
	);

	// output fifo; pend counts every decided result not yet taken
	assign push     = med_out.valid;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (fifo_cnt_q != '0);
	assign m_tdata  = DW'(fifo_pix_q[rd_ptr_q]);
	assign m_tlast  = fifo_last_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_pix_q[wr_ptr_q]  <= med_pix;
			fifo_last_q[wr_ptr_q] <= med_out.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			pend_q     <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + mfrb_pkg::PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mfrb_pkg::PTR_W'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + mfrb_pkg::CNT_W'(push) - mfrb_pkg::CNT_W'(pop);
			pend_q     <= pend_q + mfrb_pkg::CNT_W'(emit) - mfrb_pkg::CNT_W'(pop);
		end
	end

	// results in flight never exceed the fifo
	`ASSERT_AT(a_pend_bound, pend_q <= mfrb_pkg::CNT_W'(mfrb_pkg::OUT_DEPTH))
	// every buffered result was counted when it was decided
	`ASSERT_AT(a_fifo_in_pend, fifo_cnt_q <= pend_q)
	// a row start with a border radius blocks the input for its preload
	`ASSERT_NEXT(a_preload_stall, pre_start, pre_act && !s_tready)

endmodule

[hdl/mfrb_ram.sv]
// generic simple dual port ram with registered read
module mfrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/mfrb_median.sv]
// rank based median of the window, three pipeline stages
module mfrb_median #(
	parameter int PIXEL_BITS = 8,
	parameter int MAX_RADIUS = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [PIXEL_BITS-1:0]   win [2*MAX_RADIUS+1][2*MAX_RADIUS+1],
	input  logic [mfrb_pkg::RAD_W-1:0] radius,
	input  mfrb_pkg::med_meta_t     meta_in,
	output mfrb_pkg::med_meta_t     meta_out,
	output logic [PIXEL_BITS-1:0]   pix_out
);

	localparam int WIN = 2 * MAX_RADIUS + 1;
	localparam int N   = WIN * WIN;
	localparam int RKW = $clog2(N + 1);
	localparam int SDW = $clog2(WIN + 1);

	logic [PIXEL_BITS-1:0] samp [N];
	logic [N-1:0]          act;
	logic [N-1:0]          lt   [N];
	logic [SDW-1:0]        side;
	logic [RKW-1:0]        half;

	logic [N-1:0]          lt_s1   [N];
	logic [PIXEL_BITS-1:0] samp_s1 [N];
	logic [N-1:0]          act_s1;
	logic [RKW-1:0]        half_s1;
	mfrb_pkg::med_meta_t   meta_s1;

	logic [RKW-1:0]        rank_s2 [N];
	logic [PIXEL_BITS-1:0] samp_s2 [N];
	logic [N-1:0]          act_s2;
	logic [RKW-1:0]        half_s2;
	mfrb_pkg::med_meta_t   meta_s2;

	logic [PIXEL_BITS-1:0] sel;
	logic [PIXEL_BITS-1:0] pix_s3;
	mfrb_pkg::med_meta_t   meta_s3;

	// flatten, mark active taps, pairwise compare with index tie break
	always_comb begin
		side = SDW'({1'b0, radius} * 2 + 1);
		half = RKW'(({{RKW{1'b0}}, side} * {{RKW{1'b0}}, side}) >> 1);
		for (int i = 0; i < N; i++) begin
			samp[i] = win[i / WIN][i % WIN];
			act[i]  = (SDW'(i / WIN) < side) && (SDW'(i % WIN) < side);
		end
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				lt[i][j] = act[j] && ((samp[j] < samp[i]) || ((samp[j] == samp[i]) && (j < i)));
			end
		end
	end

	always_ff @(posedge clk) begin
		lt_s1   <= lt;
		samp_s1 <= samp;
		act_s1  <= act;
		half_s1 <= half;
		for (int i = 0; i < N; i++) begin
			rank_s2[i] <= RKW'($countones(lt_s1[i]));
		end
		samp_s2 <= samp_s1;
		act_s2  <= act_s1;
		half_s2 <= half_s1;
		pix_s3  <= sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
		end else begin
			meta_s1 <= meta_in;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
		end
	end

	// exactly one active tap holds the middle rank
	always_comb begin
		sel = '0;
		for (int i = 0; i < N; i++) begin
			if (act_s2[i] && (rank_s2[i] == half_s2)) begin
				sel = sel | samp_s2[i];
			end
		end
	end

	assign meta_out = meta_s3;
	assign pix_out  = pix_s3;

endmodule

[test/median_filter_replicated_border_top_tb.sv]
// testbench of the streaming median filter: random frames checked against a window predictor
module median_filter_replicated_border_top_tb;

	localparam int MAXW      = 1024;
	localparam int MAXR      = 2;
	localparam int RING      = 2 * MAXR + 2;
	localparam int DRAIN_CYC = 24;
	localparam int CFG_W     = mfrb_pkg::HEIGHT_W;
	localparam logic [1:0] CFG_UNUSED = 2'd3;   // index past the register list
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct {
		logic [7:0] pixel;
		logic       last;
	} median_beat_t;

	// mirrors the filter: line ring, positions, settings, and the medians still owed
	class median_window_checker;
		logic [7:0] ring [RING*MAXW];
		int unsigned width, height, rad;
		int unsigned in_col, in_row, out_col, out_row;
		bit frame_done;
		median_beat_t pending_medians[$];
		int errors;

		function new();
			width = 640;
			height = 480;
			rad = 1;
			errors = 0;
			restart();
		endfunction

		function void restart();
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			frame_done = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
			int unsigned v;
			case (idx)
				mfrb_pkg::CFG_WIDTH: begin
					v = data[mfrb_pkg::FW_W-1:0];
					width = (v == 0) ? 1 : (v > MAXW ? MAXW : v);
				end
				mfrb_pkg::CFG_HEIGHT: begin
					v = data;
					height = (v == 0) ? 1 :
						(v > mfrb_pkg::MAX_HEIGHT ? mfrb_pkg::MAX_HEIGHT : v);
				end
				mfrb_pkg::CFG_RADIUS: begin
					v = data[mfrb_pkg::RAD_W-1:0];
					rad = v > MAXR ? MAXR : v;
				end
				default: return;
			endcase
			restart();
		endfunction

		function int unsigned clampc(int v, int unsigned n);
			if (v < 0)
				return 0;
			if (v >= int'(n))
				return n - 1;
			return v;
		endfunction

		function logic [7:0] window_median();
			logic [7:0] samples[$];
			int unsigned y, x;
			for (int dy = -int'(rad); dy <= int'(rad); dy++) begin
				y = clampc(int'(out_row) + dy, height);
				for (int dx = -int'(rad); dx <= int'(rad); dx++) begin
					x = clampc(int'(out_col) + dx, width);
					samples = {samples, ring[(y % RING) * MAXW + x]};
				end
			end
			samples.sort();
			return samples[samples.size() / 2];
		endfunction

		// outputs of the finished frame that flush beats still have to drain
		function int unsigned medians_left();
			if (!frame_done)
				return 0;
			return width * height - (out_row * width + out_col);
		endfunction

		function void note_input_beat(logic kind, logic [7:0] pixel);
			bit ready;
			int unsigned fr, fc;
			median_beat_t m;
			if (kind == KIND_PIXEL) begin
				// a pixel after a complete frame abandons what is left of it
				if (frame_done) begin
					out_col = 0;
					out_row = 0;
					frame_done = 0;
				end
				ring[(in_row % RING) * MAXW + in_col] = pixel;
				in_col++;
				if (in_col >= width) begin
					in_col = 0;
					in_row++;
					if (in_row >= height) begin
						in_row = 0;
						frame_done = 1;
					end
				end
			end
			if (frame_done)
				ready = 1;
			else begin
				fr = (out_row + rad > height - 1) ? height - 1 : out_row + rad;
				fc = (out_col + rad > width - 1) ? width - 1 : out_col + rad;
				ready = (in_row * width + in_col) > (fr * width + fc);
			end
			if (!ready)
				return;
			m.pixel = window_median();
			m.last = 0;
			out_col++;
			if (out_col >= width) begin
				out_col = 0;
				out_row++;
				if (out_row >= height) begin
					out_row = 0;
					m.last = 1;
					frame_done = 0;
				end
			end
			pending_medians = {pending_medians, m};
		endfunction

		function void check_output_beat(logic [7:0] pixel, logic last);
			median_beat_t m;
			if (pending_medians.size() == 0) begin
				$error("unexpected output beat pixel_out=%0d frame_last=%0d", pixel, last);
				errors++;
				return;
			end
			m = pending_medians.pop_front();
			if (pixel !== m.pixel) begin
				$error("pixel_out expected %0d actual %0d", m.pixel, pixel);
				errors++;
			end
			if (last !== m.last) begin
				$error("frame_last expected %0d actual %0d", m.last, last);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;    // pixel_in
	logic [0:0]       s_tuser;    // kind
	logic             m_tvalid;
	logic             m_tready;
	logic [7:0]       m_tdata;    // pixel_out
	logic             m_tlast;    // frame_last
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	median_window_checker sb = new();
	int unsigned in_idle_pct = 0;
	int unsigned out_idle_pct = 0;
	int unsigned sent = 0;

	median_filter_replicated_border_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver: random back-pressure at the current rate
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= out_idle_pct);
	end

	// every output beat is checked against the oldest owed median
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_output_beat(m_tdata, m_tlast);
	end

	// one input beat; tvalid stays high afterwards until the next call decides
	task automatic send_beat(logic kind, logic [7:0] pixel);
		while ($urandom_range(99) < in_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= pixel;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input_beat(kind, pixel);
		sent++;
	endtask

	// lower tvalid and wait until every owed median has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_medians.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic set_frame(int unsigned w, int unsigned h, int unsigned r);
		// junk in the upper data bits must be masked by the register
		write_reg(mfrb_pkg::CFG_WIDTH, CFG_W'(w) | CFG_W'($urandom & 32'h1800));
		write_reg(mfrb_pkg::CFG_HEIGHT, CFG_W'(h));
		write_reg(mfrb_pkg::CFG_RADIUS, CFG_W'(r) | CFG_W'($urandom & 32'h1ffc));
	endtask

	// one frame of random pixels, then flushes; sometimes the tail is cut short
	task automatic random_frame(int unsigned npix);
		int unsigned left;
		for (int unsigned i = 0; i < npix; i++) begin
			if ($urandom_range(99) < 8)
				send_beat(KIND_FLUSH, 8'($urandom));
			send_beat(KIND_PIXEL, 8'($urandom));
		end
		left = sb.medians_left();
		if ($urandom_range(99) < 80)
			left = left + $urandom_range(2);
		else
			left = $urandom_range(left);
		repeat (left) send_beat(KIND_FLUSH, 8'($urandom));
	endtask

	initial begin
		int unsigned w, h;
		logic [7:0] ext_pix [6];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ext_pix = '{8'h00, 8'hff, 8'h01, 8'hfe, 8'h80, 8'h7f};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, no-radius window, flush with nothing ready
		set_frame(3, 2, 0);
		send_beat(KIND_FLUSH, 8'hff);
		foreach (ext_pix[i])
			send_beat(KIND_PIXEL, ext_pix[i]);
		send_beat(KIND_FLUSH, 8'h00);
		// flush mid-frame, then a new frame while the old one is still owed
		set_frame(4, 3, 1);
		for (int i = 0; i < 6; i++)
			send_beat(KIND_PIXEL, (i % 2) ? 8'hff : 8'h00);
		send_beat(KIND_FLUSH, 8'h00);
		for (int i = 0; i < 6; i++)
			send_beat(KIND_PIXEL, 8'(i * 51));
		send_beat(KIND_FLUSH, 8'h00);
		send_beat(KIND_PIXEL, 8'h55);
		// zero sizes act as one; ignored register index leaves the stream alone
		set_frame(0, 0, 3);
		write_reg(CFG_UNUSED, 13'h1fff);
		send_beat(KIND_PIXEL, 8'haa);
		send_beat(KIND_FLUSH, 8'h00);
		drain();

		// oversized settings clamp to the largest frame sizes, partial frames only
		set_frame(2047, 1, 3);
		random_frame(64);
		write_reg(mfrb_pkg::CFG_HEIGHT, 13'h1fff);
		write_reg(mfrb_pkg::CFG_WIDTH, 13'd1);
		random_frame(64);

		// random phases in three idling regimes
		for (int mode = 0; mode < 3; mode++) begin
			in_idle_pct = (mode == 0) ? 33 : (mode == 1) ? 68 : 0;
			out_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 33 : 0;
			sent = 0;
			while (sent < 300) begin
				w = $urandom_range(99) < 10 ? $urandom_range(40, 64) : $urandom_range(1, 12);
				h = $urandom_range(1, 8);
				set_frame(w, h, $urandom_range(3));
				repeat ($urandom_range(1, 3)) random_frame(w * h);
			end
		end
		drain();

		if (sb.errors == 0 && sb.pending_medians.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/mfrb_pkg.sv
hdl/mfrb_ram.sv
hdl/mfrb_median.sv
hdl/median_filter_replicated_border_top.sv
test/median_filter_replicated_border_top_tb.sv
